FILE: rtl/core/assert_macros.svh
// Assertion macros used by the controller of the identifier allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of i_clk while i_rst_n is released.
`define HBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks a property on every rising edge of i_clk, including during reset.
`define HBA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/hba_pkg.sv
// Package with the constants, types and helper functions of the identifier allocator.
`timescale 1ns / 1ps
`default_nettype none

package hba_pkg;

    localparam int LEVELS     = 4;
    localparam int ID_W       = 3 * LEVELS;
    localparam int CAPACITY   = 1 << ID_W;
    localparam int TREE_BYTES = (CAPACITY - 1) / 7;
    localparam int ADDR_W     = (TREE_BYTES > 1) ? $clog2(TREE_BYTES) : 1;
    localparam int LVL_W      = $clog2(LEVELS + 1);
    localparam int LIDX_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int RID_W      = 16;
    localparam int GRANT_W    = 12;
    localparam int STATUS_W   = 2;

    localparam logic [7:0] FULL_BYTE = 8'hff;
    localparam logic [7:0] TOP_MARK  = 8'h80;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    clr_wr;
        logic    load;
        logic    rd_step;
        logic    wr_step;
        logic    out_load;
        t_status out_code;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic req_bad;
        logic walk_full;
        logic lvl_top;
        logic lvl_zero;
    } t_sts;

    // Start address of a tree level, the root being level zero.
    function automatic logic [ADDR_W-1:0] level_base(input logic [LVL_W-1:0] d);
        logic [ADDR_W-1:0] base;
        base = '0;
        for (int k = 0; k < LEVELS; k++) begin
            if (k < int'(d)) begin
                base = (base << 3) + ADDR_W'(1);
            end
        end
        return base;
    endfunction

    // Position of the first clear bit counted from the MSB, eight for a full byte.
    function automatic logic [3:0] first_clear(input logic [7:0] b);
        logic [3:0] res;
        res = 4'd8;
        for (int i = 0; i < 8; i++) begin
            if (!b[i]) begin
                res = 4'(7 - i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hierarchical_bitmap_id_allocator.sv
// Top level of the hierarchical bitmap identifier allocator.
//
// Channel   Direction  Handshake                  Fields
// request   in         i_in_valid / o_in_ready    i_kind, i_release_id
// result    out        o_out_valid / i_out_ready  o_granted_id, o_status
//
// After reset the store is cleared byte by byte before a request is taken.
// An allocate or a free in range reads LEVELS + 1 times down the tree, then writes LEVELS
// times back up, all through one bitmap store; its result is then loaded into the output
// register from the done state, and the next request is taken only back in the idle state.
// A free out of range goes straight to done; an allocate on a full tree, from the read walk.
// A finished result waits in the output register while the next request is taken; the one
// after that waits in the controller, and the input stalls until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module hierarchical_bitmap_id_allocator (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_kind,
    input  wire logic [hba_pkg::RID_W-1:0]    i_release_id,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic      [hba_pkg::GRANT_W-1:0]  o_granted_id,
    output logic      [hba_pkg::STATUS_W-1:0] o_status
);
    import hba_pkg::*;

    t_cmd cmd;
    t_sts sts;

    hba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    hba_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_kind       (i_kind),
        .i_release_id (i_release_id),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_granted_id (o_granted_id),
        .o_status     (o_status)
    );

endmodule

`default_nettype wire

FILE: rtl/core/hba_datapath.sv
// Datapath of the identifier allocator: bitmap store, tree walk and result registers.
`timescale 1ns / 1ps
`default_nettype none

module hba_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_kind,
    input  wire logic [hba_pkg::RID_W-1:0]    i_release_id,
    input  wire hba_pkg::t_cmd                i_cmd,
    output hba_pkg::t_sts                     o_sts,
    output logic      [hba_pkg::GRANT_W-1:0]  o_granted_id,
    output logic      [hba_pkg::STATUS_W-1:0] o_status
);
    import hba_pkg::*;

    logic [7:0]         mem [TREE_BYTES];
    logic [7:0]         r_rdata;
    logic               r_kind;
    logic [ID_W-1:0]    r_id;
    logic [ID_W-1:0]    r_idx;
    logic [LVL_W-1:0]   r_lvl;
    logic [LVL_W-1:0]   n_lvl;
    logic [7:0]         r_path [LEVELS];
    logic [7:0]         r_child;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [GRANT_W-1:0] r_granted;
    logic [STATUS_W-1:0] r_status;

    logic [3:0]         fc;
    logic [ID_W-1:0]    n_idx;
    logic [LVL_W-1:0]   rem;
    logic [LVL_W-1:0]   lvl_m1;
    logic [ID_W-1:0]    rd_prefix;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ID_W-1:0]    wid;
    logic [ID_W-1:0]    wr_prefix;
    logic [2:0]         digit;
    logic [7:0]         mark;
    logic [7:0]         old_byte;
    logic               set_bit;
    logic [7:0]         wr_byte;
    logic [ADDR_W-1:0]  wr_addr;
    logic               m_we;
    logic [ADDR_W-1:0]  m_waddr;
    logic [7:0]         m_wdata;

    always_comb begin
        fc        = first_clear(r_rdata);
        n_idx     = (r_lvl == '0) ? r_idx : ((r_idx << 3) | ID_W'(fc[2:0]));
        rem       = LVL_W'(LEVELS) - r_lvl;
        lvl_m1    = r_lvl - LVL_W'(1);
        rd_prefix = r_kind ? (r_id >> (3 * rem)) : n_idx;
        rd_addr   = level_base(r_lvl) + ADDR_W'(rd_prefix);

        wid       = r_kind ? r_id : r_idx;
        wr_prefix = wid >> (3 * rem);
        digit     = 3'(wid >> (3 * (rem - LVL_W'(1))));
        mark      = TOP_MARK >> digit;
        old_byte  = r_path[r_lvl[LIDX_W-1:0]];
        set_bit   = (r_lvl == LVL_W'(LEVELS - 1)) ? !r_kind : (r_child == FULL_BYTE);
        wr_byte   = set_bit ? (old_byte | mark) : (old_byte & ~mark);
        wr_addr   = level_base(r_lvl) + ADDR_W'(wr_prefix);

        m_we      = i_cmd.clr_wr || i_cmd.wr_step;
        m_waddr   = i_cmd.clr_wr ? r_clr_addr : wr_addr;
        m_wdata   = i_cmd.clr_wr ? '0 : wr_byte;

        n_lvl = r_lvl;
        if (i_cmd.load) begin
            n_lvl = '0;
        end else if (i_cmd.rd_step) begin
            n_lvl = (r_lvl == LVL_W'(LEVELS)) ? LVL_W'(LEVELS - 1) : r_lvl + LVL_W'(1);
        end else if (i_cmd.wr_step) begin
            n_lvl = lvl_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            mem[m_waddr] <= m_wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_lvl      <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            r_lvl <= n_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_id   <= ID_W'(i_release_id);
            r_idx  <= '0;
        end
        if (i_cmd.rd_step && r_lvl != '0) begin
            r_path[lvl_m1[LIDX_W-1:0]] <= r_rdata;
            r_idx                      <= n_idx;
        end
        if (i_cmd.wr_step) begin
            r_child <= wr_byte;
        end
        if (i_cmd.out_load) begin
            r_granted <= (i_cmd.out_code == ST_OK && !r_kind) ? GRANT_W'(r_idx) : '0;
            r_status  <= i_cmd.out_code;
        end
    end

    always_comb begin
        o_sts.clr_last  = (r_clr_addr == ADDR_W'(TREE_BYTES - 1));
        o_sts.req_bad   = i_kind && ({1'b0, i_release_id} >= (RID_W + 1)'(CAPACITY));
        o_sts.walk_full = !r_kind && (r_lvl != '0) && fc[3];
        o_sts.lvl_top   = (r_lvl == LVL_W'(LEVELS));
        o_sts.lvl_zero  = (r_lvl == '0);
    end

    assign o_granted_id = r_granted;
    assign o_status     = r_status;

endmodule

`default_nettype wire

FILE: rtl/core/hba_ctrl.sv
// Controller state machine of the identifier allocator.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hba_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire hba_pkg::t_sts  i_sts,
    output hba_pkg::t_cmd       o_cmd
);
    import hba_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_status r_code;
    t_status n_code;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    accept;
    logic    slot_free;
    logic    walk_stop;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign slot_free = !r_out_valid || i_out_ready;
    assign walk_stop = (r_state == S_READ) && i_sts.walk_full;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_sts.req_bad) begin
                        n_state = S_DONE;
                        n_code  = ST_RANGE;
                    end else begin
                        n_state = S_READ;
                        n_code  = ST_OK;
                    end
                end
            end
            S_READ: begin
                if (i_sts.walk_full) begin
                    n_state = S_DONE;
                    n_code  = ST_FULL;
                end else if (i_sts.lvl_top) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (i_sts.lvl_zero) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.out_code = r_code;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd.clr_wr = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = accept;
            end
            S_READ:  o_cmd.rd_step  = 1'b1;
            S_WRITE: o_cmd.wr_step  = 1'b1;
            S_DONE:  o_cmd.out_load = slot_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_code      <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_code      <= n_code;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `HBA_ASSERT(a_no_overwrite, o_cmd.out_load |-> slot_free, "result overwritten")
    `HBA_ASSERT(a_one_at_a_time, accept |=> !o_in_ready, "second item taken while busy")
    `HBA_ASSERT(a_walk_only_alloc, walk_stop |=> (r_code == ST_FULL), "full walk not reported")
    `HBA_ASSERT_ALWAYS(a_reset, !i_rst_n |=> (r_state == S_CLEAR && !r_out_valid), "bad reset")

endmodule

`default_nettype wire

FILE: verif/hierarchical_bitmap_id_allocator_test.sv
// Testbench for the hierarchical bitmap identifier allocator: predictor, scoreboard, stimulus.
`timescale 1ns / 1ps

import hba_pkg::*;

localparam logic KIND_ALLOC = 1'b0;
localparam logic KIND_FREE  = 1'b1;

typedef struct packed {
    logic [GRANT_W-1:0] id;
    t_status            status;
} t_alloc_result;

class alloc_scoreboard;
    logic [7:0]    bitmap [TREE_BYTES];
    t_alloc_result expected_grants [$];
    int unsigned   errors;

    function new();
        foreach (bitmap[i]) bitmap[i] = 8'h00;
        errors = 0;
    endfunction

    function int unsigned level_start(int unsigned depth);
        int unsigned base;
        base = 0;
        for (int k = 0; k < int'(depth); k++) begin
            base = base * 8 + 1;
        end
        return base;
    endfunction

    // Sets or clears the leaf bit of an id, then rebuilds the full bits on the way to the root.
    function void mark_path(int unsigned id, bit used);
        logic [7:0]  child;
        logic [7:0]  mark;
        int unsigned pos;
        int unsigned bit_no;
        int unsigned shift;
        child = 8'h00;
        for (int d = LEVELS - 1; d >= 0; d--) begin
            shift  = 3 * (LEVELS - 1 - d);
            pos    = level_start(d) + (id >> (shift + 3));
            bit_no = (id >> shift) & 7;
            mark   = TOP_MARK >> bit_no;
            if (d == LEVELS - 1) begin
                bitmap[pos] = used ? (bitmap[pos] | mark) : (bitmap[pos] & ~mark);
            end else if (child == FULL_BYTE) begin
                bitmap[pos] = bitmap[pos] | mark;
            end else begin
                bitmap[pos] = bitmap[pos] & ~mark;
            end
            child = bitmap[pos];
        end
    endfunction

    function int unsigned pending();
        return expected_grants.size();
    endfunction

    function t_alloc_result note_request(logic kind, logic [RID_W-1:0] rid);
        t_alloc_result res;
        int unsigned   idx;
        int unsigned   pos;
        int unsigned   b;
        res.id     = '0;
        res.status = ST_OK;
        idx        = 0;
        if (kind == KIND_ALLOC) begin
            for (int d = 0; d < LEVELS; d++) begin
                pos = level_start(d) + idx;
                b   = 8;
                for (int i = 0; i < 8 && b == 8; i++) begin
                    if (!bitmap[pos][7-i]) b = i;
                end
                if (b == 8) begin
                    res.status = ST_FULL;
                    break;
                end
                idx = idx * 8 + b;
            end
            if (res.status == ST_OK) begin
                mark_path(idx, 1'b1);
                res.id = GRANT_W'(idx);
            end
        end else if (int'(rid) >= CAPACITY) begin
            res.status = ST_RANGE;
        end else begin
            mark_path(rid, 1'b0);
        end
        expected_grants.push_back(res);
        return res;
    endfunction

    function void check_result(logic [GRANT_W-1:0] gid, logic [STATUS_W-1:0] st);
        t_alloc_result exp_res;
        if (expected_grants.size() == 0) begin
            $error("Unexpected item: granted_id %0d status %0d with no request pending", gid, st);
            errors++;
            return;
        end
        exp_res = expected_grants.pop_front();
        if (gid !== exp_res.id) begin
            $error("granted_id mismatch: expected %0d, actual %0d", exp_res.id, gid);
            errors++;
        end
        if (st !== exp_res.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp_res.status, st);
            errors++;
        end
    endfunction
endclass

module hierarchical_bitmap_id_allocator_test;

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned LONG_HOLD   = 400;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                i_kind       = KIND_ALLOC;
    logic [RID_W-1:0]    i_release_id = '0;
    logic                i_out_ready  = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [GRANT_W-1:0]  o_granted_id;
    logic [STATUS_W-1:0] o_status;

    alloc_scoreboard sb;
    logic [GRANT_W-1:0] held_ids [$];
    int unsigned        hold_requests = 0;
    int unsigned        holds_served  = 0;
    int unsigned        ready_left    = 0;
    int unsigned        cycle_count   = 0;

    hierarchical_bitmap_id_allocator u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_release_id (i_release_id),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_granted_id (o_granted_id),
        .o_status     (o_status)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_granted_id, o_status);
        end
        if (hold_requests != holds_served) begin
            holds_served++;
            ready_left = LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (ready_left > 0) begin
            ready_left--;
        end else if ($urandom_range(99) < 60) begin
            ready_left = $urandom_range(20, 1) - 1;
            i_out_ready <= 1'b1;
        end else begin
            ready_left = pick_gap();
            i_out_ready <= 1'b0;
        end
    end

    task automatic send_item(input logic kind, input logic [RID_W-1:0] rid);
        int unsigned   gap;
        t_alloc_result exp_res;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_release_id <= rid;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        exp_res = sb.note_request(kind, rid);
        if (kind == KIND_ALLOC && exp_res.status == ST_OK) held_ids.push_back(exp_res.id);
    endtask

    task automatic random_item(input int unsigned alloc_pct);
        int unsigned      r;
        int unsigned      k;
        logic [RID_W-1:0] rid;
        r   = $urandom_range(99);
        rid = RID_W'($urandom);
        if (r < alloc_pct) begin
            send_item(KIND_ALLOC, rid);
        end else if (r < alloc_pct + (100 - alloc_pct) * 4 / 5 && held_ids.size() > 0) begin
            k = $urandom_range(held_ids.size() - 1);
            rid = RID_W'(held_ids[k]);
            held_ids.delete(k);
            send_item(KIND_FREE, rid);
        end else if ($urandom_range(1) == 0) begin
            send_item(KIND_FREE, rid);
        end else begin
            send_item(KIND_FREE, RID_W'($urandom_range(CAPACITY - 1)));
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(KIND_ALLOC, 16'h0000);
        send_item(KIND_ALLOC, 16'hffff);
        send_item(KIND_ALLOC, 16'h1234);
        send_item(KIND_FREE, 16'd1);
        send_item(KIND_ALLOC, 16'h0000);
        send_item(KIND_FREE, RID_W'(CAPACITY));
        send_item(KIND_FREE, 16'hffff);
        send_item(KIND_FREE, RID_W'(CAPACITY - 1));
        send_item(KIND_FREE, 16'd0);
        send_item(KIND_ALLOC, 16'h0000);
        send_item(KIND_FREE, 16'h8000);
        send_item(KIND_FREE, 16'h0aaa);
        send_item(KIND_FREE, 16'h5555);
        repeat (6) send_item(KIND_ALLOC, 16'h0000);
        send_item(KIND_FREE, 16'd3);
        send_item(KIND_ALLOC, 16'h0000);
        held_ids.delete();
        for (int i = 0; i < 9; i++) held_ids.push_back(GRANT_W'(i));
        wait_drained();

        for (int n = 0; n < 800; n++) begin
            if (n == 200) hold_requests++;
            random_item(65);
        end
        wait_drained();

        hold_requests++;
        for (int n = 0; n < 20; n++) random_item(50);
        wait_drained();

        for (int n = 0; n < 900; n++) random_item(30);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/hba_pkg.sv
rtl/core/hba_datapath.sv
rtl/core/hba_ctrl.sv
rtl/core/hierarchical_bitmap_id_allocator.sv
verif/hierarchical_bitmap_id_allocator_test.sv
